// ===== rtl/rdc_pkg.sv =====
// Package for the radix digit converter: shared widths, character constants,
// register index, sequencer state type, clamp and digit-to-ASCII helpers.
// No dependencies.
package rdc_pkg;

  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  // Quotient bits resolved by the long-division unit in one cycle.
  localparam int STEP_BITS  = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;
  localparam logic [CHAR_W-1:0] LETTER_GAP = 7'd39;

  // Register index, taken from paddr[2].
  localparam logic REG_RADIX = 1'b0;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_READ = 5'b00100,
    S_LOAD = 5'b01000,
    S_SEND = 5'b10000
  } state_e;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = {1'b0, d} + CHAR_ZERO;
    if (c > CHAR_NINE) begin
      c = c + LETTER_GAP;
    end
    return c;
  endfunction

endpackage

// ===== rtl/rdc_if.sv =====
// Valid/ready channel interfaces for the radix digit converter.
// Depends on rdc_pkg for the character width.
interface rdc_in_if #(
  parameter int VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rdc_out_if;
  logic                        valid;
  logic                        ready;
  logic [rdc_pkg::CHAR_W-1:0]  digit_char;
  logic                        is_last;

  modport source (output valid, output digit_char, output is_last, input ready);
  modport sink   (input valid, input digit_char, input is_last, output ready);
endinterface

// ===== rtl/rdc_divider.sv =====
// Shared long-division unit: divides a value by the radix, STEP_BITS quotient
// bits per cycle, giving quotient and remainder. Depends on rdc_pkg.
module rdc_divider #(
  parameter int VALUE_BITS = 31
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rdc_pkg::RADIX_W-1:0] radix_i,
  input  logic [VALUE_BITS-1:0]       dividend_i,
  output logic                        done_o,
  output logic [VALUE_BITS-1:0]       quot_o,
  output logic [rdc_pkg::RADIX_W-1:0] rem_o
);
  import rdc_pkg::*;

  localparam int PASSES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int WORK_W = PASSES * STEP_BITS;
  localparam int CNT_W  = $clog2(PASSES + 1);

  // The work register shifts dividend bits out at the top and quotient bits
  // in at the bottom, so it holds the quotient after the last pass.
  logic [WORK_W-1:0]    work_q, work_d;
  logic [RADIX_W-1:0]   rem_q, rem_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic [STEP_BITS-1:0] chunk;
  logic [STEP_BITS-1:0] qbits;
  logic [RADIX_W-1:0]   rem_step;
  logic [RADIX_W:0]     part;

  assign done_o = busy_q && (cnt_q == CNT_W'(PASSES));
  assign quot_o = work_q[VALUE_BITS-1:0];
  assign rem_o  = rem_q;

  always_comb begin
    chunk    = work_q[WORK_W-1 -: STEP_BITS];
    rem_step = rem_q;
    qbits    = '0;
    part     = '0;
    for (int j = 0; j < STEP_BITS; j++) begin
      part = {rem_step, chunk[STEP_BITS-1-j]};
      if (part >= {1'b0, radix_i}) begin
        part                  = part - {1'b0, radix_i};
        qbits[STEP_BITS-1-j]  = 1'b1;
      end
      rem_step = part[RADIX_W-1:0];
    end
  end

  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      work_d = WORK_W'(dividend_i);
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q && !done_o) begin
      work_d = (work_q << STEP_BITS) | WORK_W'(qbits);
      rem_d  = rem_step;
      cnt_d  = cnt_q + CNT_W'(1);
    end else if (done_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
  end

endmodule

// ===== rtl/rdc_digit_buf.sv =====
// Digit buffer: holds the remainders least significant first so they can be
// read back in reverse. Registered read. Depends on rdc_pkg.
module rdc_digit_buf #(
  parameter int DEPTH = 31
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr_i,
  input  logic [rdc_pkg::RADIX_W-1:0] wr_data_i,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr_i,
  output logic [rdc_pkg::RADIX_W-1:0] rd_data_o
);
  import rdc_pkg::*;

  logic [RADIX_W-1:0] mem_q [DEPTH];
  logic [RADIX_W-1:0] rd_data_q;

  assign rd_data_o = rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

endmodule

// ===== rtl/radix_digit_converter.sv =====
// Top level of the radix digit converter: sequencer, radix register, APB port.
// Depends on rdc_pkg, rdc_if, rdc_divider and rdc_digit_buf.
//
// Usage: a value arrives as one beat on the input channel; the block then
// emits its digits in the configured radix as ASCII characters, most
// significant first, one beat per digit, with is_last set on the final one.
// A zero value gives the single digit '0'. The radix register sits at APB
// address 0, resets to 10 and is clamped to the range 2 to 36 when used.
// Timing: input ready is high only while idle. The shared divider, which
// resolves eight quotient bits a cycle, first works out every digit into
// the digit buffer; each digit is then read back (S_READ), turned into its
// ASCII character (S_LOAD) and presented (S_SEND). A new value is taken
// only after the last digit of the current one has been taken.
// When the receiver stalls, the current digit beat is held unchanged until
// taken. Reset returns the block to idle with no beat pending.
module radix_digit_converter #(
  parameter int VALUE_BITS = 31
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rdc_in_if.sink                         in_if,
  rdc_out_if.source                      out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rdc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rdc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rdc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rdc_pkg::*;

  localparam int IDX_W = $clog2(VALUE_BITS);

  state_e               state_q, state_d;
  logic [RADIX_W-1:0]   radix_q;
  logic [RADIX_W-1:0]   radix_eff;
  logic [IDX_W-1:0]     ndig_q, ndig_d;
  logic [IDX_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CHAR_W-1:0]    digit_char_q, digit_char_d;
  logic                 is_last_q, is_last_d;
  logic                 div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                 div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [RADIX_W-1:0]   div_rem;
  logic                 buf_we;
  logic [RADIX_W-1:0]   buf_rd;
  logic                 reg_sel;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_RADIX);
  assign prdata  = reg_sel ? APB_DATA_W'(radix_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      radix_q <= pwdata[RADIX_W-1:0];
    end
  end

  assign radix_eff = clamp_radix(radix_q);

  rdc_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .radix_i    (radix_eff),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  rdc_digit_buf #(
    .DEPTH (VALUE_BITS)
  ) u_digit_buf (
    .clk_i     (clk_i),
    .wr_en_i   (buf_we),
    .wr_addr_i (ndig_q),
    .wr_data_i (div_rem),
    .rd_addr_i (rd_ptr_q),
    .rd_data_o (buf_rd)
  );

  // Sequencer: divide repeatedly until the quotient is zero, then read the
  // stored remainders back from the highest index down.
  always_comb begin
    state_d      = state_q;
    ndig_d       = ndig_q;
    rd_ptr_d     = rd_ptr_q;
    digit_char_d = digit_char_q;
    is_last_d    = is_last_q;
    div_start    = 1'b0;
    div_dividend = in_if.value;
    buf_we       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          div_start = 1'b1;
          ndig_d    = '0;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          buf_we = 1'b1;
          if (div_quot == '0) begin
            rd_ptr_d = ndig_q;
            state_d  = S_READ;
          end else begin
            div_start    = 1'b1;
            div_dividend = div_quot;
            ndig_d       = ndig_q + IDX_W'(1);
          end
        end
      end
      S_READ: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        digit_char_d = digit_to_ascii(buf_rd);
        is_last_d    = (rd_ptr_q == '0);
        state_d      = S_SEND;
      end
      S_SEND: begin
        if (out_if.ready) begin
          if (is_last_q) begin
            state_d = S_IDLE;
          end else begin
            rd_ptr_d = rd_ptr_q - IDX_W'(1);
            state_d  = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ndig_q   <= '0;
      rd_ptr_q <= '0;
    end else begin
      state_q  <= state_d;
      ndig_q   <= ndig_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_char_q <= digit_char_d;
    is_last_q    <= is_last_d;
  end

  assign in_if.ready       = (state_q == S_IDLE);
  assign out_if.valid      = (state_q == S_SEND);
  assign out_if.digit_char = digit_char_q;
  assign out_if.is_last    = is_last_q;

endmodule

// ===== rtl/rdc_checker.sv =====
// Port-level assertions for the radix digit converter, bound to the top level.
// Depends on rdc_pkg and radix_digit_converter.
module rdc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rdc_pkg::CHAR_W-1:0] digit_char,
  input logic                       is_last
);
  import rdc_pkg::*;

  // The block works on one value at a time: no digit is offered while idle.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid))
    else $error("digit beat offered while input is ready");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready after a value was accepted");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && is_last) |=> in_ready)
    else $error("block not idle after the last digit beat");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(digit_char) && $stable(is_last)))
    else $error("stalled digit beat changed");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> ((digit_char >= CHAR_ZERO && digit_char <= CHAR_NINE) ||
                   (digit_char >= 7'd97 && digit_char <= 7'd122)))
    else $error("digit character outside the alphabet");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .digit_char (out_if.digit_char),
  .is_last    (out_if.is_last)
);

// ===== bench/tb_radix_digit_converter.sv =====
// Self-checking bench for radix_digit_converter: directed and random values over several
// radix settings and idling phases; digit beats are checked against an in-bench predictor.
// Depends on rdc_pkg, rdc_in_if, rdc_out_if and the radix_digit_converter RTL.
module tb_radix_digit_converter;
  timeunit 1ns;
  timeprecision 1ps;
  import rdc_pkg::*;

  localparam int VALUE_BITS = 31;
  localparam logic [APB_ADDR_W-1:0] RADIX_ADDR = {REG_RADIX, 2'b00};

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              is_last;
  } digit_beat_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rdc_in_if #(.VALUE_BITS(VALUE_BITS)) in_bus ();
  rdc_out_if                           out_bus ();

  radix_digit_converter #(.VALUE_BITS(VALUE_BITS)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_bus),
    .out_if (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  logic [RADIX_W-1:0] radix_reg;
  digit_beat_t        pending_digits[$];
  int                 err_count;
  int                 src_idle_pct;
  int                 sink_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned active_radix();
    if (radix_reg < RADIX_MIN) begin
      return RADIX_MIN;
    end else if (radix_reg > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return radix_reg;
  endfunction

  // Splits the value into digits of the active radix and queues one beat per digit,
  // most significant first.
  function automatic void queue_digits_of(input logic [VALUE_BITS-1:0] value);
    logic [RADIX_W-1:0] held[$];
    longint unsigned    rest;
    longint unsigned    base;
    digit_beat_t        beat;
    rest = value;
    base = active_radix();
    do begin
      held.push_front(RADIX_W'(rest % base));
      rest = rest / base;
    end while (rest != 0);
    foreach (held[i]) begin
      beat.digit_char = CHAR_W'(held[i]) + CHAR_ZERO;
      if (beat.digit_char > CHAR_NINE) begin
        beat.digit_char = beat.digit_char + LETTER_GAP;
      end
      beat.is_last = (i == held.size() - 1);
      pending_digits.push_back(beat);
    end
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    longint unsigned top;
    longint unsigned span;
    longint unsigned base;
    int unsigned     width;
    top  = (64'd1 << VALUE_BITS) - 1;
    base = active_radix();
    case ($urandom_range(0, 3))
      0: begin
        return VALUE_BITS'($urandom());
      end
      1: begin
        width = $urandom_range(1, VALUE_BITS);
        return VALUE_BITS'($urandom() & ((64'd1 << width) - 1));
      end
      2: begin
        // Land next to a power of the radix, where the digit count changes.
        span = 1;
        repeat ($urandom_range(1, VALUE_BITS)) begin
          if (span * base <= top) begin
            span = span * base;
          end
        end
        span = span - 1 + $urandom_range(0, 2);
        if (span > top) begin
          span = top;
        end
        return VALUE_BITS'(span);
      end
      default: begin
        return VALUE_BITS'($urandom_range(0, 3 * base));
      end
    endcase
  endfunction

  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.value <= v;
    do @(posedge clk_i); while (!in_bus.ready);
    queue_digits_of(v);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes the radix register once the block is idle, then reads it back.
  task automatic write_radix(input logic [APB_DATA_W-1:0] data);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RADIX_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    radix_reg = data[RADIX_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DATA_W'(radix_reg)) begin
      $display("%0t: radix read back expected %0d got %0d", $time, radix_reg, prdata);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_radix();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_value('0);
    send_value(VALUE_BITS'(1));
    send_value(VALUE_BITS'(9));
    send_value(VALUE_BITS'(10));
    send_value('1);
    send_value(VALUE_BITS'(1000000000));
    send_value(VALUE_BITS'(999999999));
  endtask

  task automatic test_radix_extremes();
    write_radix(32'd2);
    send_value('0);
    send_value(VALUE_BITS'(1));
    send_value('1);
    send_value(VALUE_BITS'(1) << (VALUE_BITS - 1));
    write_radix(32'd36);
    send_value(VALUE_BITS'(35));
    send_value(VALUE_BITS'(36));
    send_value('1);
    // Out-of-range settings saturate to the nearest legal radix.
    write_radix(32'd0);
    send_value(VALUE_BITS'(5));
    write_radix(32'd1);
    send_value(VALUE_BITS'(5));
    write_radix(32'd37);
    send_value(VALUE_BITS'(35));
    write_radix(32'd63);
    send_value(VALUE_BITS'(1295));
    // Only the low six bits of the write data land in the register.
    write_radix(32'hABCD_EF10);
    send_value(VALUE_BITS'(32'h0DEA_DBEE));
    send_value(VALUE_BITS'(255));
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                     input logic [RADIX_W-1:0] first_radix, input int count);
    logic [RADIX_W-1:0] r;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 18 == 0) begin
        if (n == 0) begin
          r = first_radix;
        end else if ($urandom_range(0, 3) == 0) begin
          r = RADIX_W'($urandom_range(0, 63));
        end else begin
          r = RADIX_W'($urandom_range(2, 36));
        end
        write_radix(($urandom() & 32'hFFFF_FFC0) | APB_DATA_W'(r));
      end
      send_value(pick_value());
    end
  endtask

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    digit_beat_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected digit beat, char %0d last %0b", $time,
                 out_bus.digit_char, out_bus.is_last);
        err_count++;
      end else begin
        want = pending_digits.pop_front();
        if (out_bus.digit_char !== want.digit_char) begin
          $display("%0t: digit_char expected %0d got %0d", $time,
                   want.digit_char, out_bus.digit_char);
          err_count++;
        end
        if (out_bus.is_last !== want.is_last) begin
          $display("%0t: is_last expected %0b got %0b", $time, want.is_last, out_bus.is_last);
          err_count++;
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("tb_radix_digit_converter: errors");
    $finish;
  end

  initial begin
    err_count      = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    radix_reg      = RADIX_RESET;
    rst_ni        <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.value  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_radix();
    test_radix_extremes();
    test_random_traffic(0, 0, RADIX_MAX, 72);
    test_random_traffic(78, 0, RADIX_MIN, 72);
    test_random_traffic(0, 78, 6'd10, 72);
    test_random_traffic(13, 13, 6'd7, 72);

    wait_drained();
    repeat (32) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_radix_digit_converter: clean");
    end else begin
      $display("tb_radix_digit_converter: errors");
    end
    $finish;
  end

endmodule
